// ===== src/sfs_pkg.sv =====
`timescale 1ns / 1ps
package sfs_pkg;

  // input opcodes
  typedef enum logic [1:0] {
    OPC_REQUEST = 2'd0,
    OPC_WDATA   = 2'd1,
    OPC_REPLY   = 2'd2,
    OPC_NONE    = 2'd3
  } opcode_t;

  // host commands
  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_SERASE  = 3'd2,
    CMD_CERASE  = 3'd3,
    CMD_STATUS  = 3'd4,
    CMD_ID      = 3'd5,
    CMD_PDOWN   = 3'd6,
    CMD_RELEASE = 3'd7
  } command_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SPI  = 2'd0,
    KIND_HOST = 2'd1,
    KIND_DONE = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  // flash instruction bytes
  localparam logic [7:0] FL_WREN    = 8'h06;
  localparam logic [7:0] FL_PROG    = 8'h02;
  localparam logic [7:0] FL_SERASE  = 8'h20;
  localparam logic [7:0] FL_READ    = 8'h03;
  localparam logic [7:0] FL_RDSR    = 8'h05;
  localparam logic [7:0] FL_CERASE  = 8'hC7;
  localparam logic [7:0] FL_ID      = 8'h90;
  localparam logic [7:0] FL_PDOWN   = 8'hB9;
  localparam logic [7:0] FL_RELEASE = 8'hAB;
  localparam logic [7:0] FL_DUMMY   = 8'hFF;

  typedef enum logic [4:0] {
    PH_IDLE, PH_COLLECT, PH_RD, PH_ST, PH_ID, PH_PWR,
    PH_CE_WREN, PH_CE_POLL1, PH_CE_CMD, PH_CE_POLL2,
    PH_SE_WREN, PH_SE_POLL1, PH_SE_CMD, PH_SE_POLL2,
    PH_W_READ, PH_W_WREN, PH_W_POLL1, PH_W_ERASE, PH_W_POLL2,
    PH_PG_WREN, PH_PG_PROG, PH_PG_POLL
  } phase_t;

  typedef enum logic [2:0] {
    B_WAIT, B_DISPATCH, B_SEND, B_SENDD, B_FDONE, B_NEXTPAGE, B_SECTOR, B_FIN
  } bstate_t;

  typedef struct packed {
    opcode_t     opc;
    command_t    command;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  spi_byte;
    logic        frame_end;
    logic [15:0] host_value;
    logic        status;
    logic        last;
  } result_t;

endpackage

// ===== src/sfs_front.sv =====
`timescale 1ns / 1ps
module sfs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           opcode,
  input  logic [2:0]           command,
  input  logic [23:0]          address,
  input  logic [15:0]          length,
  input  logic [7:0]           data_byte,
  output logic                 item_valid,
  output sfs_pkg::item_t       item,
  input  logic                 item_take
);
  import sfs_pkg::*;

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       enq, deq;
  item_t      w;

  // opcode 3 is dropped here: it never causes a result
  always_comb begin
    w.opc       = opcode_t'(opcode);
    w.command   = command_t'(command);
    w.address   = address;
    w.length    = length;
    w.data_byte = data_byte;
  end

  assign full       = (cnt == 2'd2);
  assign enq        = push && !full && (w.opc != OPC_NONE);
  assign deq        = item_take && item_valid;
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rp];

  always_ff @(posedge clk) begin
    if (enq) q[wp] <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= 2'(cnt + {1'b0, enq} - {1'b0, deq});
    end
  end
endmodule

// ===== src/sfs_outq.sv =====
`timescale 1ns / 1ps
module sfs_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sfs_pkg::result_t wdata,
  output logic             room,
  output logic             empty,
  output sfs_pkg::result_t rdata,
  input  logic             pop
);
  import sfs_pkg::*;

  result_t    q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       deq;

  assign empty = (cnt == 3'd0);
  assign room  = (cnt <= 3'd1);   // one item may push up to two words
  assign rdata = q[rp];
  assign deq   = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (wr)  wp <= 2'(wp + 2'd1);
      if (deq) rp <= 2'(rp + 2'd1);
      cnt <= 3'(cnt + {2'b0, wr} - {2'b0, deq});
    end
  end
endmodule

// ===== src/sfs_back.sv =====
`timescale 1ns / 1ps
module sfs_back #(
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int WRITE_BUFFER = 4096,
  parameter int ADDRESS_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  sfs_pkg::item_t   item,
  output logic             item_take,
  input  logic             room,
  output logic             res_push,
  output sfs_pkg::result_t res
);
  import sfs_pkg::*;

  localparam int AW   = ADDRESS_BITS;
  localparam int SOW  = $clog2(SECTOR_BYTES);
  localparam int SCW  = SOW + 1;
  localparam int PBW  = $clog2(PAGE_BYTES);
  localparam int PGW  = PBW + 1;
  localparam int WBW  = $clog2(WRITE_BUFFER);
  localparam int MAXB = (SECTOR_BYTES > WRITE_BUFFER) ? SECTOR_BYTES : WRITE_BUFFER;
  localparam int FW   = $clog2(MAXB + 5);

  logic [7:0] sector_store [SECTOR_BYTES];
  logic [7:0] write_store  [WRITE_BUFFER];

  bstate_t          bstate, bstate_next;
  phase_t           phase, phase_next;
  item_t            it, it_next;
  logic [3:0][7:0]  hdr, hdr_next;
  logic [2:0]       hdr_len, hdr_len_next;
  logic [FW-1:0]    frame_len, frame_len_next;
  logic [FW-1:0]    bc, bc_next;
  logic             body_is_data, body_is_data_next;
  logic [AW-1:0]    sec_base, sec_base_next;
  logic [SOW-1:0]   sec_off, sec_off_next;
  logic [SCW-1:0]   sec_cnt, sec_cnt_next;
  logic [SCW-1:0]   prog_pos, prog_pos_next;
  logic [SCW-1:0]   prog_end, prog_end_next;
  logic [PGW-1:0]   page_len, page_len_next;
  logic [15:0]      reply_reg, reply_reg_next;
  logic [AW-1:0]    cur, cur_next;
  logic [15:0]      bytes_left, bytes_left_next;
  logic [15:0]      dp, dp_next;
  logic             needs_erase, needs_erase_next;
  result_t          held, held_next;
  logic             held_valid, held_valid_next;
  logic             rd_in;

  // store ports
  logic             ws_we, ss_we;
  logic [WBW-1:0]   ws_waddr, ws_raddr;
  logic [SOW-1:0]   ss_waddr, ss_raddr;
  logic [7:0]       ss_wdata, ws_q, ss_q;

  // program body read address
  logic [SCW-1:0]   o_rd;
  logic             o_rd_in;

  assign o_rd     = SCW'(prog_pos + SCW'(bc - FW'(4)));
  assign o_rd_in  = (o_rd >= SCW'(sec_off)) && (SCW'(o_rd - SCW'(sec_off)) < sec_cnt);
  assign ws_raddr = WBW'(dp + 16'(o_rd - SCW'(sec_off)));
  assign ss_raddr = o_rd[SOW-1:0];

  always_ff @(posedge clk) begin
    if (ws_we) write_store[ws_waddr] <= it.data_byte;
    ws_q <= write_store[ws_raddr];
  end

  always_ff @(posedge clk) begin
    if (ss_we) sector_store[ss_waddr] <= ss_wdata;
    ss_q <= sector_store[ss_raddr];
  end

  always_ff @(posedge clk) begin
    rd_in <= o_rd_in;
    it    <= it_next;
    held  <= held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate       <= B_WAIT;
      phase        <= PH_IDLE;
      hdr          <= '0;
      hdr_len      <= '0;
      frame_len    <= '0;
      bc           <= '0;
      body_is_data <= 1'b0;
      sec_base     <= '0;
      sec_off      <= '0;
      sec_cnt      <= '0;
      prog_pos     <= '0;
      prog_end     <= '0;
      page_len     <= '0;
      reply_reg    <= '0;
      cur          <= '0;
      bytes_left   <= '0;
      dp           <= '0;
      needs_erase  <= 1'b0;
      held_valid   <= 1'b0;
    end else begin
      bstate       <= bstate_next;
      phase        <= phase_next;
      hdr          <= hdr_next;
      hdr_len      <= hdr_len_next;
      frame_len    <= frame_len_next;
      bc           <= bc_next;
      body_is_data <= body_is_data_next;
      sec_base     <= sec_base_next;
      sec_off      <= sec_off_next;
      sec_cnt      <= sec_cnt_next;
      prog_pos     <= prog_pos_next;
      prog_end     <= prog_end_next;
      page_len     <= page_len_next;
      reply_reg    <= reply_reg_next;
      cur          <= cur_next;
      bytes_left   <= bytes_left_next;
      dp           <= dp_next;
      needs_erase  <= needs_erase_next;
      held_valid   <= held_valid_next;
    end
  end

  always_comb begin
    logic           sf_go, sf_addr, sf_data;
    phase_t         sf_phase;
    logic [7:0]     sf_op;
    logic [AW-1:0]  sf_a;
    logic [FW-1:0]  sf_body;
    logic           em_go;
    result_t        em;
    logic           is_poll;
    logic [FW-1:0]  p;
    logic [SCW-1:0] o2;
    logic [23:0]    a24;
    logic [15:0]    dp_inc, bl_new;
    logic [AW-1:0]  pa;
    logic [PGW-1:0] proom;
    logic [SCW-1:0] rem, sroom;
    logic [SOW-1:0] off;

    bstate_next       = bstate;
    phase_next        = phase;
    it_next           = it;
    hdr_next          = hdr;
    hdr_len_next      = hdr_len;
    frame_len_next    = frame_len;
    bc_next           = bc;
    body_is_data_next = body_is_data;
    sec_base_next     = sec_base;
    sec_off_next      = sec_off;
    sec_cnt_next      = sec_cnt;
    prog_pos_next     = prog_pos;
    prog_end_next     = prog_end;
    page_len_next     = page_len;
    reply_reg_next    = reply_reg;
    cur_next          = cur;
    bytes_left_next   = bytes_left;
    dp_next           = dp;
    needs_erase_next  = needs_erase;
    held_next         = held;
    held_valid_next   = held_valid;
    item_take         = 1'b0;
    res_push          = 1'b0;
    res               = held;
    ws_we             = 1'b0;
    ws_waddr          = dp[WBW-1:0];
    ss_we             = 1'b0;
    ss_waddr          = '0;
    ss_wdata          = it.data_byte;

    sf_go    = 1'b0;
    sf_addr  = 1'b0;
    sf_data  = 1'b0;
    sf_phase = PH_IDLE;
    sf_op    = FL_WREN;
    sf_a     = '0;
    sf_body  = '0;
    em_go    = 1'b0;
    em       = '0;
    is_poll  = phase inside {PH_CE_POLL1, PH_CE_POLL2, PH_SE_POLL1, PH_SE_POLL2,
                             PH_W_POLL1, PH_W_POLL2, PH_PG_POLL};
    p        = FW'(bc - FW'(1));
    o2       = SCW'(bc - FW'(5));
    dp_inc   = 16'(dp + 16'd1);
    bl_new   = 16'(bytes_left - 16'(sec_cnt));
    pa       = AW'(sec_base + AW'(prog_pos));
    proom    = PGW'(PAGE_BYTES) - PGW'(pa[PBW-1:0]);
    rem      = SCW'(prog_end - prog_pos);
    off      = cur[SOW-1:0];
    sroom    = SCW'(SECTOR_BYTES) - SCW'(off);

    case (bstate)
      B_WAIT: begin
        if (item_valid && room) begin
          item_take   = 1'b1;
          it_next     = item;
          bstate_next = B_DISPATCH;
        end
      end

      B_DISPATCH: begin
        bstate_next = B_FIN;
        case (it.opc)
          OPC_REQUEST: begin
            if (phase != PH_IDLE) begin
              em_go = 1'b1; em.kind = KIND_DONE; em.status = 1'b1;
            end else if ((it.command == CMD_READ || it.command == CMD_WRITE) &&
                         (it.length == '0 ||
                          {1'b0, it.length} > 17'(WRITE_BUFFER))) begin
              em_go = 1'b1; em.kind = KIND_DONE; em.status = 1'b1;
              bc_next = '0;
            end else begin
              case (it.command)
                CMD_READ: begin
                  sf_go = 1'b1; sf_phase = PH_RD; sf_op = FL_READ; sf_addr = 1'b1;
                  sf_a = it.address[AW-1:0]; sf_body = FW'(it.length);
                end
                CMD_WRITE: begin
                  bytes_left_next = it.length;
                  cur_next        = it.address[AW-1:0];
                  dp_next         = '0;
                  phase_next      = PH_COLLECT;
                end
                CMD_SERASE: begin
                  sec_base_next = {it.address[AW-1:SOW], SOW'(0)};
                  sf_go = 1'b1; sf_phase = PH_SE_WREN; sf_op = FL_WREN;
                end
                CMD_CERASE: begin
                  sf_go = 1'b1; sf_phase = PH_CE_WREN; sf_op = FL_WREN;
                end
                CMD_STATUS: begin
                  sf_go = 1'b1; sf_phase = PH_ST; sf_op = FL_RDSR; sf_body = FW'(1);
                end
                CMD_ID: begin
                  sf_go = 1'b1; sf_phase = PH_ID; sf_op = FL_ID; sf_addr = 1'b1;
                  sf_body = FW'(2);
                end
                CMD_PDOWN: begin
                  sf_go = 1'b1; sf_phase = PH_PWR; sf_op = FL_PDOWN;
                end
                default: begin
                  sf_go = 1'b1; sf_phase = PH_PWR; sf_op = FL_RELEASE;
                end
              endcase
            end
          end

          OPC_WDATA: begin
            if (phase == PH_COLLECT) begin
              ws_we = 1'b1;
              if (dp_inc >= bytes_left) begin
                dp_next     = '0;
                bstate_next = B_SECTOR;
              end else begin
                dp_next = dp_inc;
              end
            end
          end

          default: begin
            // flash reply answers the byte sent last
            if (phase != PH_IDLE && phase != PH_COLLECT && bc != '0) begin
              if (phase == PH_RD) begin
                if (p >= FW'(hdr_len)) begin
                  em_go = 1'b1; em.kind = KIND_HOST;
                  em.host_value = {8'h00, it.data_byte};
                end
              end else if (phase == PH_ST || is_poll) begin
                if (p == FW'(1)) reply_reg_next = {8'h00, it.data_byte};
              end else if (phase == PH_ID) begin
                if (p == FW'(4)) reply_reg_next = {it.data_byte, 8'h00};
                else if (p == FW'(5)) reply_reg_next = {reply_reg[15:8], it.data_byte};
              end else if (phase == PH_W_READ && p >= FW'(4)) begin
                ss_we    = 1'b1;
                ss_waddr = o2[SOW-1:0];
                if (o2 >= SCW'(sec_off) && SCW'(o2 - SCW'(sec_off)) < sec_cnt &&
                    it.data_byte != FL_DUMMY)
                  needs_erase_next = 1'b1;
              end
              bstate_next = (bc < frame_len) ? B_SEND : B_FDONE;
            end
          end
        endcase
      end

      B_SEND: begin
        if (bc < FW'(hdr_len)) begin
          em_go = 1'b1; em.kind = KIND_SPI; em.spi_byte = hdr[bc[1:0]];
          em.frame_end = (FW'(bc + FW'(1)) == frame_len);
          bc_next = FW'(bc + FW'(1));
          bstate_next = B_FIN;
        end else if (body_is_data) begin
          bstate_next = B_SENDD;
        end else begin
          em_go = 1'b1; em.kind = KIND_SPI; em.spi_byte = FL_DUMMY;
          em.frame_end = (FW'(bc + FW'(1)) == frame_len);
          bc_next = FW'(bc + FW'(1));
          bstate_next = B_FIN;
        end
      end

      B_SENDD: begin
        em_go = 1'b1; em.kind = KIND_SPI; em.spi_byte = rd_in ? ws_q : ss_q;
        em.frame_end = (FW'(bc + FW'(1)) == frame_len);
        bc_next = FW'(bc + FW'(1));
        bstate_next = B_FIN;
      end

      B_FDONE: begin
        bstate_next = B_FIN;
        if (is_poll && reply_reg[0]) begin
          sf_go = 1'b1; sf_phase = phase; sf_op = FL_RDSR; sf_body = FW'(1);
        end else begin
          case (phase)
            PH_RD, PH_PWR, PH_CE_POLL2, PH_SE_POLL2: begin
              em_go = 1'b1; em.kind = KIND_DONE; phase_next = PH_IDLE; bc_next = '0;
            end
            PH_ST: begin
              em_go = 1'b1; em.kind = KIND_DONE; em.host_value = {8'h00, reply_reg[7:0]};
              phase_next = PH_IDLE; bc_next = '0;
            end
            PH_ID: begin
              em_go = 1'b1; em.kind = KIND_DONE; em.host_value = reply_reg;
              phase_next = PH_IDLE; bc_next = '0;
            end
            PH_CE_WREN: begin
              sf_go = 1'b1; sf_phase = PH_CE_POLL1; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_CE_POLL1: begin
              sf_go = 1'b1; sf_phase = PH_CE_CMD; sf_op = FL_CERASE;
            end
            PH_CE_CMD: begin
              sf_go = 1'b1; sf_phase = PH_CE_POLL2; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_SE_WREN: begin
              sf_go = 1'b1; sf_phase = PH_SE_POLL1; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_SE_POLL1: begin
              sf_go = 1'b1; sf_phase = PH_SE_CMD; sf_op = FL_SERASE; sf_addr = 1'b1;
              sf_a = sec_base;
            end
            PH_SE_CMD: begin
              sf_go = 1'b1; sf_phase = PH_SE_POLL2; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_W_READ: begin
              if (needs_erase) begin
                sf_go = 1'b1; sf_phase = PH_W_WREN; sf_op = FL_WREN;
              end else begin
                prog_pos_next = SCW'(sec_off);
                prog_end_next = SCW'(SCW'(sec_off) + sec_cnt);
                bstate_next   = B_NEXTPAGE;
              end
            end
            PH_W_WREN: begin
              sf_go = 1'b1; sf_phase = PH_W_POLL1; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_W_POLL1: begin
              sf_go = 1'b1; sf_phase = PH_W_ERASE; sf_op = FL_SERASE; sf_addr = 1'b1;
              sf_a = sec_base;
            end
            PH_W_ERASE: begin
              sf_go = 1'b1; sf_phase = PH_W_POLL2; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_W_POLL2: begin
              prog_pos_next = '0;
              prog_end_next = SCW'(SECTOR_BYTES);
              bstate_next   = B_NEXTPAGE;
            end
            PH_PG_WREN: begin
              sf_go = 1'b1; sf_phase = PH_PG_PROG; sf_op = FL_PROG; sf_addr = 1'b1;
              sf_a = pa; sf_body = FW'(page_len); sf_data = 1'b1;
            end
            PH_PG_PROG: begin
              sf_go = 1'b1; sf_phase = PH_PG_POLL; sf_op = FL_RDSR; sf_body = FW'(1);
            end
            PH_PG_POLL: begin
              prog_pos_next = SCW'(prog_pos + SCW'(page_len));
              bstate_next   = B_NEXTPAGE;
            end
            default: begin
              phase_next = PH_IDLE; bc_next = '0;
            end
          endcase
        end
      end

      B_NEXTPAGE: begin
        if (prog_pos >= prog_end) begin
          // sector finished: advance to the next one or close the request
          dp_next         = 16'(dp + 16'(sec_cnt));
          bytes_left_next = bl_new;
          cur_next        = AW'(cur + AW'(sec_cnt));
          if (bl_new == '0) begin
            em_go = 1'b1; em.kind = KIND_DONE; phase_next = PH_IDLE; bc_next = '0;
            bstate_next = B_FIN;
          end else begin
            bstate_next = B_SECTOR;
          end
        end else begin
          page_len_next = (rem < SCW'(proom)) ? PGW'(rem) : proom;
          sf_go = 1'b1; sf_phase = PH_PG_WREN; sf_op = FL_WREN;
          bstate_next = B_FIN;
        end
      end

      B_SECTOR: begin
        sec_off_next     = off;
        sec_base_next    = {cur[AW-1:SOW], SOW'(0)};
        sec_cnt_next     = ({1'b0, bytes_left} < 17'(sroom)) ? SCW'(bytes_left) : sroom;
        needs_erase_next = 1'b0;
        sf_go = 1'b1; sf_phase = PH_W_READ; sf_op = FL_READ; sf_addr = 1'b1;
        sf_a = {cur[AW-1:SOW], SOW'(0)}; sf_body = FW'(SECTOR_BYTES);
        bstate_next = B_FIN;
      end

      B_FIN: begin
        if (held_valid) begin
          res_push      = 1'b1;
          res           = held;
          res.last      = 1'b1;
        end
        held_valid_next = 1'b0;
        bstate_next     = B_WAIT;
      end

      default: bstate_next = B_WAIT;
    endcase

    // new frame: load header, first byte goes out from B_SEND
    if (sf_go) begin
      a24               = 24'(sf_a);
      phase_next        = sf_phase;
      hdr_next          = {a24[7:0], a24[15:8], a24[23:16], sf_op};
      hdr_len_next      = sf_addr ? 3'd4 : 3'd1;
      frame_len_next    = FW'((sf_addr ? FW'(4) : FW'(1)) + sf_body);
      body_is_data_next = sf_data;
      bc_next           = '0;
      bstate_next       = B_SEND;
    end else begin
      a24 = '0;
    end

    // hold the newest word back so that the final one can carry last
    if (em_go) begin
      if (held_valid) begin
        res_push = 1'b1;
        res      = held;
        res.last = 1'b0;
      end
      held_next       = em;
      held_valid_next = 1'b1;
    end
  end

  a_wait_clean: assert property (@(posedge clk) disable iff (rst)
    bstate == B_WAIT |-> !held_valid)
    else $error("word left held while waiting");

  a_sendd_order: assert property (@(posedge clk) disable iff (rst)
    bstate == B_SENDD |-> $past(bstate) == B_SEND)
    else $error("store data emitted without a read");

  a_sector_frame: assert property (@(posedge clk) disable iff (rst)
    phase == PH_W_READ |-> frame_len == FW'(SECTOR_BYTES + 4))
    else $error("sector read frame of wrong length");

endmodule

// ===== src/spi_nor_flash_sequencer_top.sv =====
`timescale 1ns / 1ps
// Host side sequencer for a serial NOR flash. Items come in through a queue
// port (push/full): host requests, write data words and bytes received from
// the flash, each reply answering the SPI byte sent last. Results leave
// through a queue port (empty/pop): SPI bytes with a frame end mark, host read
// bytes and a done word per request, the final word of each item flagged last.
// A front stage classifies items into a two-deep queue; a back sequencer
// works one item at a time and owns the sector and write stores. In the back
// an item always passes through pick-up, dispatch and close, and between
// these through at most one frame close, one page step and one sector start
// ahead of the send that opens a frame, and a data byte of a program frame
// adds a store read. Pick-up waits while more than one result word is still
// queued. Writes read back the whole sector, erase it only if a target byte
// is not blank, and program merged pages behind a write enable, polling the
// busy bit after each erase and program.
module spi_nor_flash_sequencer_top #(
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int WRITE_BUFFER = 4096,
  parameter int ADDRESS_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [2:0]  command,
  input  logic [23:0] address,
  input  logic [15:0] length,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  spi_byte,
  output logic        frame_end,
  output logic [15:0] host_value,
  output logic        status,
  output logic        last
);
  import sfs_pkg::*;

  logic    item_valid, item_take, room, res_push;
  item_t   item;
  result_t res, head;

  sfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .command    (command),
    .address    (address),
    .length     (length),
    .data_byte  (data_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  sfs_back #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .PAGE_BYTES   (PAGE_BYTES),
    .WRITE_BUFFER (WRITE_BUFFER),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .room       (room),
    .res_push   (res_push),
    .res        (res)
  );

  sfs_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .room  (room),
    .empty (empty),
    .rdata (head),
    .pop   (pop)
  );

  assign kind       = head.kind;
  assign spi_byte   = head.spi_byte;
  assign frame_end  = head.frame_end;
  assign host_value = head.host_value;
  assign status     = head.status;
  assign last       = head.last;
endmodule

// ===== verif/spi_nor_flash_sequencer_check.sv =====
`timescale 1ns / 1ps
// Watches both queue ports, predicts the result words and compares them.
module spi_nor_flash_sequencer_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [2:0]  command,
  input  logic [23:0] address,
  input  logic [15:0] length,
  input  logic [7:0]  data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  kind,
  input  logic [7:0]  spi_byte,
  input  logic        frame_end,
  input  logic [15:0] host_value,
  input  logic        status,
  input  logic        last,
  output int          fail_count,
  output int          waiting
);
  import sfs_pkg::*;

  localparam int SECTOR = 4096;
  localparam int PAGE   = 256;
  localparam int WBUF   = 4096;

  phase_t      ph;
  logic [7:0]  sec_img [SECTOR];
  logic [7:0]  wr_buf [WBUF];
  logic [23:0] cur_addr;
  int          left, bcnt, wr_ptr;
  bit          erase_needed;
  logic [7:0]  hdr [4];
  int          hdr_n, frm_n;
  bit          body_data;
  int          sbase, soff, scnt;
  int          ppos, pstop, plen;
  int          reply_val;

  result_t     step_q[$];
  result_t     due_q[$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void put(kind_t k, logic [7:0] sb, logic fe, logic [15:0] hv,
                              logic st);
    result_t r;
    r.kind = k; r.spi_byte = sb; r.frame_end = fe;
    r.host_value = hv; r.status = st; r.last = 1'b0;
    if (step_q.size() < 3) step_q.push_back(r);
  endfunction

  function automatic void finish_req(logic [15:0] hv, logic st);
    put(KIND_DONE, 8'h00, 1'b0, hv, st);
    ph = PH_IDLE;
    bcnt = 0;
  endfunction

  function automatic logic [7:0] merged(int o);
    int idx;
    if (o >= soff && o - soff < scnt) begin
      idx = wr_ptr + (o - soff);
      return (idx < WBUF) ? wr_buf[idx] : 8'h00;
    end
    return (o < SECTOR) ? sec_img[o] : 8'h00;
  endfunction

  function automatic void send_byte();
    int p;
    logic [7:0] v;
    p = bcnt;
    if (p < hdr_n) v = hdr[p & 3];
    else if (body_data) v = merged(ppos + (p - hdr_n));
    else v = FL_DUMMY;
    put(KIND_SPI, v, (p + 1 == frm_n), 16'h0, 1'b0);
    bcnt++;
  endfunction

  function automatic void hdr1(logic [7:0] op);
    hdr[0] = op; hdr_n = 1;
  endfunction

  function automatic void hdr4(logic [7:0] op, logic [23:0] a);
    hdr[0] = op; hdr[1] = a[23:16]; hdr[2] = a[15:8]; hdr[3] = a[7:0];
    hdr_n = 4;
  endfunction

  function automatic void open_frame(phase_t p, int body, bit d);
    ph = p;
    frm_n = hdr_n + body;
    body_data = d;
    bcnt = 0;
    send_byte();
  endfunction

  function automatic void wren(phase_t p);
    hdr1(FL_WREN); open_frame(p, 0, 1'b0);
  endfunction

  function automatic void poll(phase_t p);
    hdr1(FL_RDSR); open_frame(p, 1, 1'b0);
  endfunction

  function automatic void sector_begin();
    int off, room;
    off = int'(cur_addr[11:0]);
    room = SECTOR - off;
    soff = off;
    sbase = int'(cur_addr) - off;
    scnt = (left < room) ? left : room;
    erase_needed = 1'b0;
    hdr4(FL_READ, sbase[23:0]);
    open_frame(PH_W_READ, SECTOR, 1'b0);
  endfunction

  function automatic void page_step();
    int a, room, rem;
    if (ppos >= pstop) begin
      wr_ptr += scnt;
      left -= scnt;
      cur_addr = cur_addr + scnt[23:0];
      if (left == 0) finish_req(16'h0, 1'b0);
      else sector_begin();
      return;
    end
    a = (sbase + ppos) & 32'hFFFFFF;
    room = PAGE - a % PAGE;
    rem = pstop - ppos;
    plen = (rem < room) ? rem : room;
    wren(PH_PG_WREN);
  endfunction

  function automatic bit is_poll(phase_t p);
    return p inside {PH_CE_POLL1, PH_CE_POLL2, PH_SE_POLL1, PH_SE_POLL2,
                     PH_W_POLL1, PH_W_POLL2, PH_PG_POLL};
  endfunction

  function automatic void frame_close();
    int a;
    if (is_poll(ph) && reply_val[0]) begin
      poll(ph);
      return;
    end
    case (ph)
      PH_RD, PH_PWR: finish_req(16'h0, 1'b0);
      PH_ST:         finish_req({8'h0, reply_val[7:0]}, 1'b0);
      PH_ID:         finish_req(reply_val[15:0], 1'b0);
      PH_CE_WREN:    poll(PH_CE_POLL1);
      PH_CE_POLL1: begin
        hdr1(FL_CERASE); open_frame(PH_CE_CMD, 0, 1'b0);
      end
      PH_CE_CMD:     poll(PH_CE_POLL2);
      PH_CE_POLL2:   finish_req(16'h0, 1'b0);
      PH_SE_WREN:    poll(PH_SE_POLL1);
      PH_SE_POLL1: begin
        hdr4(FL_SERASE, sbase[23:0]); open_frame(PH_SE_CMD, 0, 1'b0);
      end
      PH_SE_CMD:     poll(PH_SE_POLL2);
      PH_SE_POLL2:   finish_req(16'h0, 1'b0);
      PH_W_READ: begin
        if (erase_needed) wren(PH_W_WREN);
        else begin
          ppos = soff; pstop = soff + scnt; page_step();
        end
      end
      PH_W_WREN:     poll(PH_W_POLL1);
      PH_W_POLL1: begin
        hdr4(FL_SERASE, sbase[23:0]); open_frame(PH_W_ERASE, 0, 1'b0);
      end
      PH_W_ERASE:    poll(PH_W_POLL2);
      PH_W_POLL2: begin
        ppos = 0; pstop = SECTOR; page_step();
      end
      PH_PG_WREN: begin
        a = (sbase + ppos) & 32'hFFFFFF;
        hdr4(FL_PROG, a[23:0]);
        open_frame(PH_PG_PROG, plen, 1'b1);
      end
      PH_PG_PROG:    poll(PH_PG_POLL);
      PH_PG_POLL: begin
        ppos += plen; page_step();
      end
      default: begin
        ph = PH_IDLE; bcnt = 0;
      end
    endcase
  endfunction

  function automatic void flash_byte(logic [7:0] b);
    int p, o;
    if (ph == PH_IDLE || ph == PH_COLLECT || bcnt == 0) return;
    p = bcnt - 1;
    if (ph == PH_RD) begin
      if (p >= hdr_n) put(KIND_HOST, 8'h0, 1'b0, {8'h0, b}, 1'b0);
    end else if (ph == PH_ST || is_poll(ph)) begin
      if (p == 1) reply_val = int'(b);
    end else if (ph == PH_ID) begin
      if (p == 4) reply_val = int'(b) << 8;
      else if (p == 5) reply_val |= int'(b);
    end else if (ph == PH_W_READ && p >= 4) begin
      o = p - 4;
      if (o < SECTOR) sec_img[o] = b;
      if (o >= soff && o - soff < scnt && b != FL_DUMMY) erase_needed = 1'b1;
    end
    if (bcnt < frm_n) send_byte();
    else frame_close();
  endfunction

  function automatic void host_request(logic [2:0] cmd, logic [23:0] a, int len);
    if (ph != PH_IDLE) begin
      put(KIND_DONE, 8'h0, 1'b0, 16'h0, 1'b1);
      return;
    end
    if (cmd <= CMD_WRITE && (len == 0 || len > WBUF)) begin
      finish_req(16'h0, 1'b1);
      return;
    end
    case (command_t'(cmd))
      CMD_READ: begin
        hdr4(FL_READ, a); open_frame(PH_RD, len, 1'b0);
      end
      CMD_WRITE: begin
        left = len; cur_addr = a; wr_ptr = 0; ph = PH_COLLECT;
      end
      CMD_SERASE: begin
        sbase = int'({a[23:12], 12'h000}); wren(PH_SE_WREN);
      end
      CMD_CERASE: wren(PH_CE_WREN);
      CMD_STATUS: begin
        hdr1(FL_RDSR); open_frame(PH_ST, 1, 1'b0);
      end
      CMD_ID: begin
        hdr4(FL_ID, 24'h0); open_frame(PH_ID, 2, 1'b0);
      end
      CMD_PDOWN: begin
        hdr1(FL_PDOWN); open_frame(PH_PWR, 0, 1'b0);
      end
      default: begin
        hdr1(FL_RELEASE); open_frame(PH_PWR, 0, 1'b0);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ph = PH_IDLE; cur_addr = '0; left = 0; bcnt = 0; wr_ptr = 0;
      erase_needed = 1'b0; hdr_n = 0; frm_n = 0; body_data = 1'b0;
      sbase = 0; soff = 0; scnt = 0; ppos = 0; pstop = 0; plen = 0;
      reply_val = 0; hdr = '{default: 8'h00};
      due_q.delete();
      fail_count = 0;
    end else begin
      if (push && !full) begin
        step_q.delete();
        case (opcode)
          OPC_REQUEST: host_request(command, address, int'(length));
          OPC_WDATA: begin
            if (ph == PH_COLLECT) begin
              if (wr_ptr < WBUF) wr_buf[wr_ptr] = data_byte;
              wr_ptr++;
              if (wr_ptr >= left) begin
                wr_ptr = 0; sector_begin();
              end
            end
          end
          OPC_REPLY: flash_byte(data_byte);
          default: ;
        endcase
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) due_q.push_back(step_q[i]);
      end
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          report("word with nothing due, kind", 32'(kind), 32'h0);
        end else begin
          want = due_q.pop_front();
          if (kind != want.kind) report("kind", 32'(kind), 32'(want.kind));
          if (spi_byte != want.spi_byte)
            report("spi_byte", 32'(spi_byte), 32'(want.spi_byte));
          if (frame_end != want.frame_end)
            report("frame_end", 32'(frame_end), 32'(want.frame_end));
          if (host_value != want.host_value)
            report("host_value", 32'(host_value), 32'(want.host_value));
          if (status != want.status) report("status", 32'(status), 32'(want.status));
          if (last != want.last) report("last", 32'(last), 32'(want.last));
        end
      end
    end
    waiting <= due_q.size();
  end

endmodule

// ===== verif/spi_nor_flash_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict. The top plays both the host and the flash: it issues
// requests, feeds write data words and answers every SPI byte the block sends
// with one reply word. Checking lives in the checker beside the block.
module spi_nor_flash_sequencer_top_tb;
  import sfs_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  opcode;
  logic [2:0]  command;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  spi_byte;
  logic        frame_end;
  logic [15:0] host_value;
  logic        status;
  logic        last;

  int          fail_count;
  int          waiting;

  // idle odds, in percent
  int          send_idle;
  int          recv_idle;

  // flash side bookkeeping: SPI bytes taken from the block versus replies given
  int          spi_seen;
  int          answered;
  logic [7:0]  last_spi, prev_spi;
  logic        last_fe;
  bit          fill_blank;
  int          writes_left;

  spi_nor_flash_sequencer_top DUT (.*);

  spi_nor_flash_sequencer_check checker_i (.*, .fail_count(fail_count), .waiting(waiting));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling; a healthy run finishes well inside it.
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls on pop.
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  // Track SPI words leaving the block so the flash model knows what is owed.
  always @(posedge clk) begin
    if (rst) begin
      spi_seen <= 0;
      last_spi <= 8'h00;
      prev_spi <= 8'h00;
      last_fe  <= 1'b0;
    end else if (pop && !empty && kind == KIND_SPI) begin
      spi_seen <= spi_seen + 1;
      prev_spi <= last_spi;
      last_spi <= spi_byte;
      last_fe  <= frame_end;
    end
  end

  // One word into the input queue, with random idling ahead of it. push is
  // left high on return so back-to-back words need no second assignment.
  task automatic push_word(logic [1:0] opc, logic [2:0] cmd, logic [23:0] a,
                           logic [15:0] len, logic [7:0] db);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    opcode    <= opc;
    command   <= cmd;
    address   <= a;
    length    <= len;
    data_byte <= db;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Flash reply. A two-byte frame opened by read-status is a busy poll or a
  // status read: mostly not busy so polls end. Otherwise blank or mixed data,
  // which decides whether a write has to erase its sector.
  task automatic flash_reply();
    logic [7:0] r;
    if (prev_spi == FL_RDSR && last_fe) begin
      r = 8'($urandom_range(255));
      if ($urandom_range(99) < 70) r[0] = 1'b0;
    end else if (fill_blank) begin
      r = FL_DUMMY;
    end else begin
      case ($urandom_range(3))
        0:       r = 8'hFF;
        1:       r = 8'h00;
        default: r = 8'($urandom_range(255));
      endcase
    end
    push_word(OPC_REPLY, 3'($urandom_range(7)), 24'($urandom), 16'($urandom), r);
    answered++;
  endtask

  // Answer the flash until nothing is owed and nothing is due. The checker's
  // count is registered, hence the second look before leaving.
  task automatic settle();
    while (1) begin
      if (spi_seen != answered) begin
        flash_reply();
      end else begin
        push <= 1'b0;
        @(posedge clk);
        if (waiting == 0 && spi_seen == answered) break;
      end
    end
  endtask

  // One host request, its write data words if it opens a write, and an
  // optional second request that must bounce as busy.
  task automatic request(logic [2:0] cmd, logic [23:0] a, logic [15:0] len, bit blank,
                         bit intrude);
    bit ok;
    fill_blank = blank;
    ok = !(cmd <= CMD_WRITE && (len == 0 || len > 16'd4096));
    push_word(OPC_REQUEST, cmd, a, len, 8'($urandom));
    if (cmd == CMD_WRITE && ok) begin
      for (int i = 0; i < int'(len); i++)
        push_word(OPC_WDATA, 3'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
    end
    if (intrude && ok)
      push_word(OPC_REQUEST, 3'($urandom_range(7)), 24'($urandom), 16'($urandom),
                8'($urandom));
    settle();
  endtask

  // Words the block must drop while idle: junk opcode, stray data, stray reply.
  task automatic stray_words();
    push_word(OPC_NONE, 3'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
    push_word(OPC_WDATA, 3'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
    push_word(OPC_REPLY, 3'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
    settle();
  endtask

  initial begin
    logic [2:0]  cmd;
    logic [23:0] a;
    logic [15:0] len;
    int          pick;

    rst = 1'b1;
    push = 1'b0;
    opcode = OPC_NONE;
    command = CMD_READ;
    address = '0;
    length = '0;
    data_byte = '0;
    send_idle = 16;
    recv_idle = 59;
    answered = 0;
    fill_blank = 1'b1;
    writes_left = 6;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command, field extremes, address wrap, length limits.
    request(CMD_STATUS,  24'h000000, 16'h0000, 1'b0, 1'b0);
    request(CMD_ID,      24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0);
    request(CMD_PDOWN,   24'h000000, 16'h0000, 1'b0, 1'b0);
    request(CMD_RELEASE, 24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0);
    request(CMD_SERASE,  24'hFFFFFF, 16'h0000, 1'b0, 1'b0);
    request(CMD_CERASE,  24'h000000, 16'h0000, 1'b0, 1'b0);
    request(CMD_READ,    24'h000000, 16'd1,    1'b0, 1'b0);
    request(CMD_READ,    24'hFFFFFE, 16'd4,    1'b0, 1'b0);
    request(CMD_READ,    24'h123456, 16'd4096, 1'b0, 1'b0);
    request(CMD_READ,    24'h000010, 16'd0,    1'b0, 1'b0);
    request(CMD_READ,    24'h000010, 16'd4097, 1'b0, 1'b0);
    request(CMD_WRITE,   24'h000010, 16'd0,    1'b0, 1'b0);
    request(CMD_WRITE,   24'h000010, 16'hFFFF, 1'b0, 1'b0);
    // blank sector: program only the target bytes
    request(CMD_WRITE,   24'h000100, 16'd4,    1'b1, 1'b0);
    // page boundary inside a blank write
    request(CMD_WRITE,   24'h1000FF, 16'd2,    1'b1, 1'b0);
    // crosses the top of the address space into sector zero, likely erasing
    request(CMD_WRITE,   24'hFFFFF8, 16'd16,   1'b0, 1'b0);
    // second request while the first is running
    request(CMD_READ,    24'h00ABCD, 16'd3,    1'b0, 1'b1);
    request(CMD_WRITE,   24'h000200, 16'd3,    1'b1, 1'b1);
    stray_words();

    // Random: three idling regimes in turn, the block settled between them.
    for (int i = 0; i < 84; i++) begin
      if (i == 28) begin
        send_idle = 59;
        recv_idle = 16;
      end else if (i == 56) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(9) == 0) stray_words();
      cmd = 3'($urandom_range(7));
      if (cmd == CMD_WRITE) begin
        if (writes_left == 0) cmd = CMD_READ;
        else writes_left--;
      end
      a = 24'($urandom);
      pick = $urandom_range(99);
      if (cmd == CMD_WRITE) begin
        if (pick < 20) a[11:4] = 8'hFF;
        len = (pick < 85) ? 16'($urandom_range(1, 24)) : 16'($urandom_range(200, 400));
      end else if (cmd == CMD_READ) begin
        if (pick < 80) len = 16'($urandom_range(1, 16));
        else if (pick < 90) len = 16'($urandom_range(17, 600));
        else if (pick < 95) len = 16'd0;
        else len = 16'($urandom_range(4097, 65535));
      end else begin
        len = 16'($urandom);
      end
      request(cmd, a, len, $urandom_range(1), $urandom_range(9) == 0);
    end

    push <= 1'b0;
    repeat (40) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
